### design/tfst_pkg.sv
// ----------------------------------------------------------------------------
// tfst_pkg
// Types and constants shared by the TCP flow state table.
// ----------------------------------------------------------------------------
package tfst_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_APPLY1,
    ST_APPLY2,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MODE_FLUSH,
    MODE_SWEEP,
    MODE_LOOK
  } mode_t;

  localparam logic [1:0] EV_CREATED   = 2'd0;
  localparam logic [1:0] EV_DELETED   = 2'd1;
  localparam logic [1:0] EV_PROCESSED = 2'd2;

  localparam logic [1:0] PH_HALF = 2'd0;
  localparam logic [1:0] PH_FULL = 2'd1;
  localparam logic [1:0] PH_RST  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  localparam logic [2:0] REG_HALF_TMO  = 3'd0;
  localparam logic [2:0] REG_FULL_TMO  = 3'd1;
  localparam logic [2:0] REG_RST_TMO   = 3'd2;
  localparam logic [2:0] REG_FIN_TMO   = 3'd3;
  localparam logic [2:0] REG_SWEEP_INT = 3'd4;

  localparam int KEY_W = 96;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
  } key_t;

  typedef struct packed {
    logic [1:0] kind;
    key_t       key;
    logic [1:0] phase;
    logic       full;
  } res_t;

endpackage

### design/tfst_in_if.sv
// ----------------------------------------------------------------------------
// tfst_in_if
// Packet / command channel into the flow table.
// ----------------------------------------------------------------------------
interface tfst_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] stamp_seconds;
  logic        has_ip;
  logic        has_tcp;
  logic [31:0] source_addr;
  logic [15:0] source_port;
  logic [31:0] dest_addr;
  logic [15:0] dest_port;
  logic        rst_bit;
  logic        fin_bit;

  modport source (output valid, command, stamp_seconds, has_ip, has_tcp, source_addr,
                  source_port, dest_addr, dest_port, rst_bit, fin_bit, input ready);
  modport sink (input valid, command, stamp_seconds, has_ip, has_tcp, source_addr,
                source_port, dest_addr, dest_port, rst_bit, fin_bit, output ready);
endinterface

### design/tfst_out_if.sv
// ----------------------------------------------------------------------------
// tfst_out_if
// Event channel out of the flow table.
// ----------------------------------------------------------------------------
interface tfst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] flow_src_addr;
  logic [15:0] flow_src_port;
  logic [31:0] flow_dst_addr;
  logic [15:0] flow_dst_port;
  logic [1:0]  flow_phase;
  logic        table_full;
  logic        last;

  modport source (output valid, event_kind, flow_src_addr, flow_src_port, flow_dst_addr,
                  flow_dst_port, flow_phase, table_full, last, input ready);
  modport sink (input valid, event_kind, flow_src_addr, flow_src_port, flow_dst_addr,
                flow_dst_port, flow_phase, table_full, last, output ready);
endinterface

### design/tfst_cfg_if.sv
// ----------------------------------------------------------------------------
// tfst_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface tfst_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/tcp_flow_state_table.sv
// ----------------------------------------------------------------------------
// tcp_flow_state_table
// TCP flow table keyed by four-tuple, with per-phase aging sweeps and flush.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      beat
//  in_ch    in   valid/ready    one packet or flush command
//  out_ch   out  valid/ready    one created/deleted/processed event, last on final
//  cfg_ch   in   valid/ready    register index + 16-bit value
//
//  Each slot is visited as a RAM read, then an evaluate, by one shared
//  compare unit. A TCP packet walks every slot once for lookup, after a
//  sweep walk over every slot when a sweep is due; a flush walks every slot once.
//  Reset clears valid bits and last_sweep; no clearing pass.
//  Output backpressure stalls the walk whenever an event cannot be queued.
module tcp_flow_state_table #(
  parameter int FLOW_ENTRIES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  tfst_in_if.sink      in_ch,
  tfst_out_if.source   out_ch,
  tfst_cfg_if.sink     cfg_ch
);
  import tfst_pkg::*;

  localparam int IW = $clog2(FLOW_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(FLOW_ENTRIES - 1);

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [31:0] now_r, now_nxt;
  key_t key_r, key_nxt;
  logic pkt_ok_r, pkt_ok_nxt, rst_r, rst_nxt, fin_r, fin_nxt;
  logic [FLOW_ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0] last_sweep_r, last_sweep_nxt;
  logic [15:0] half_tmo_r, full_tmo_r, rst_tmo_r, fin_tmo_r, sweep_int_r;
  logic slot_found_r, slot_found_nxt, rfound_r, rfound_nxt, free_found_r, free_found_nxt;
  logic [IW-1:0] slot_r, slot_nxt, rslot_r, rslot_nxt, free_r, free_nxt;
  logic [1:0] slot_phase_r, slot_phase_nxt;
  logic rev_upd_r, rev_upd_nxt;
  logic pend_v_r, pend_v_nxt;
  res_t pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_r, out_nxt;
  logic out_last_r, out_last_nxt;

  // RAM ports
  key_t rd_key;
  logic [1:0] rd_phase;
  logic [31:0] rd_seen;
  logic key_we, phase_we, seen_we;
  logic [IW-1:0] key_wa, phase_wa, seen_wa;
  logic [1:0] phase_wd;

  tfst_ram #(.WIDTH(KEY_W), .DEPTH(FLOW_ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_r), .raddr(idx_r), .rdata(rd_key)
  );
  tfst_ram #(.WIDTH(2), .DEPTH(FLOW_ENTRIES)) u_phase_ram (
    .clk(clk), .we(phase_we), .waddr(phase_wa), .wdata(phase_wd), .raddr(idx_r),
    .rdata(rd_phase)
  );
  tfst_ram #(.WIDTH(32), .DEPTH(FLOW_ENTRIES)) u_seen_ram (
    .clk(clk), .we(seen_we), .waddr(seen_wa), .wdata(now_r), .raddr(idx_r), .rdata(rd_seen)
  );

  // configuration
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_tmo_r  <= 16'd60;
      full_tmo_r  <= 16'd180;
      rst_tmo_r   <= 16'd10;
      fin_tmo_r   <= 16'd20;
      sweep_int_r <= 16'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_HALF_TMO:  half_tmo_r  <= cfg_ch.data;
        REG_FULL_TMO:  full_tmo_r  <= cfg_ch.data;
        REG_RST_TMO:   rst_tmo_r   <= cfg_ch.data;
        REG_FIN_TMO:   fin_tmo_r   <= cfg_ch.data;
        REG_SWEEP_INT: sweep_int_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic in_acc, out_free, push_ok;
  logic emit_v, finish_v;
  res_t emit_d;
  logic [32:0] sweep_diff, age_diff;
  logic sweep_go, aged, is_new, has_slot, flags;
  logic [15:0] tmo;
  logic [1:0] st_flag, final_phase;
  logic [IW-1:0] tgt;
  key_t in_key, rev_key;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign push_ok     = !pend_v_r || out_free;

  always_comb begin
    in_key = '{src_addr: in_ch.source_addr, src_port: in_ch.source_port,
               dst_addr: in_ch.dest_addr, dst_port: in_ch.dest_port};
    rev_key = '{src_addr: key_r.dst_addr, src_port: key_r.dst_port,
                dst_addr: key_r.src_addr, dst_port: key_r.src_port};
    sweep_diff = {1'b0, in_ch.stamp_seconds} - {1'b0, last_sweep_r};
    sweep_go = (sweep_int_r != 16'd0) && !sweep_diff[32] &&
               (sweep_diff[31:0] >= {16'd0, sweep_int_r});
    case (rd_phase)
      PH_HALF: tmo = half_tmo_r;
      PH_FULL: tmo = full_tmo_r;
      PH_RST:  tmo = rst_tmo_r;
      default: tmo = fin_tmo_r;
    endcase
    age_diff = {1'b0, now_r} - {1'b0, rd_seen};
    aged = !age_diff[32] && (age_diff[31:0] >= {16'd0, tmo});
    flags = rst_r || fin_r;
    st_flag = rst_r ? PH_RST : PH_FIN;
    is_new = !slot_found_r && free_found_r;
    has_slot = slot_found_r || free_found_r;
    tgt = slot_found_r ? slot_r : free_r;
    if (flags) begin
      final_phase = st_flag;
    end else if (slot_found_r) begin
      final_phase = slot_phase_r;
    end else begin
      final_phase = rfound_r ? PH_FULL : PH_HALF;
    end

    state_nxt = state_r;
    mode_nxt = mode_r;
    idx_nxt = idx_r;
    now_nxt = now_r;
    key_nxt = key_r;
    pkt_ok_nxt = pkt_ok_r;
    rst_nxt = rst_r;
    fin_nxt = fin_r;
    valid_nxt = valid_r;
    last_sweep_nxt = last_sweep_r;
    slot_found_nxt = slot_found_r;
    rfound_nxt = rfound_r;
    free_found_nxt = free_found_r;
    slot_nxt = slot_r;
    rslot_nxt = rslot_r;
    free_nxt = free_r;
    slot_phase_nxt = slot_phase_r;
    rev_upd_nxt = rev_upd_r;
    emit_v = 1'b0;
    emit_d = '0;
    finish_v = 1'b0;
    key_we = 1'b0;
    key_wa = free_r;
    phase_we = 1'b0;
    phase_wa = tgt;
    phase_wd = final_phase;
    seen_we = 1'b0;
    seen_wa = tgt;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          now_nxt = in_ch.stamp_seconds;
          key_nxt = in_key;
          pkt_ok_nxt = in_ch.has_ip && in_ch.has_tcp;
          rst_nxt = in_ch.rst_bit;
          fin_nxt = in_ch.fin_bit;
          idx_nxt = '0;
          slot_found_nxt = 1'b0;
          rfound_nxt = 1'b0;
          free_found_nxt = 1'b0;
          if (in_ch.command) begin
            mode_nxt = MODE_FLUSH;
            state_nxt = ST_RD;
          end else if (sweep_go) begin
            mode_nxt = MODE_SWEEP;
            last_sweep_nxt = in_ch.stamp_seconds;
            state_nxt = ST_RD;
          end else if (in_ch.has_ip && in_ch.has_tcp) begin
            mode_nxt = MODE_LOOK;
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_RD: state_nxt = ST_EV;
      ST_EV: begin
        logic go;
        go = 1'b1;
        case (mode_r)
          MODE_FLUSH, MODE_SWEEP: begin
            if (valid_r[idx_r] && (mode_r == MODE_FLUSH || aged)) begin
              if (push_ok) begin
                emit_v = 1'b1;
                emit_d = '{kind: EV_DELETED, key: rd_key, phase: rd_phase, full: 1'b0};
                valid_nxt[idx_r] = 1'b0;
              end else begin
                go = 1'b0;
              end
            end
          end
          default: begin
            if (valid_r[idx_r] && rd_key == key_r && !slot_found_r) begin
              slot_found_nxt = 1'b1;
              slot_nxt = idx_r;
              slot_phase_nxt = rd_phase;
            end
            if (valid_r[idx_r] && rd_key == rev_key && !rfound_r) begin
              rfound_nxt = 1'b1;
              rslot_nxt = idx_r;
            end
            if (!valid_r[idx_r] && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_nxt = idx_r;
            end
          end
        endcase
        if (go) begin
          if (idx_r == LAST_IDX) begin
            idx_nxt = '0;
            case (mode_r)
              MODE_FLUSH: state_nxt = ST_FINISH;
              MODE_SWEEP: begin
                if (pkt_ok_r) begin
                  mode_nxt = MODE_LOOK;
                  state_nxt = ST_RD;
                end else begin
                  state_nxt = ST_FINISH;
                end
              end
              default: state_nxt = ST_APPLY1;
            endcase
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_APPLY1: begin
        if (!is_new || push_ok) begin
          if (is_new) begin
            emit_v = 1'b1;
            emit_d = '{kind: EV_CREATED, key: key_r, phase: PH_HALF, full: 1'b0};
            key_we = 1'b1;
            valid_nxt[free_r] = 1'b1;
          end
          phase_we = has_slot;
          seen_we = has_slot;
          slot_found_nxt = has_slot;
          slot_phase_nxt = final_phase;
          rev_upd_nxt = rfound_r && (flags || is_new);
          state_nxt = ST_APPLY2;
        end
      end
      ST_APPLY2: begin
        phase_wa = rslot_r;
        phase_wd = flags ? st_flag : PH_FULL;
        if (push_ok) begin
          phase_we = rev_upd_r;
          emit_v = 1'b1;
          emit_d = '{kind: EV_PROCESSED, key: key_r,
                     phase: slot_found_r ? slot_phase_r : PH_HALF, full: !slot_found_r};
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          finish_v = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // one-deep holding stage so the final event can carry last
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt = out_r;
    out_last_nxt = out_last_r;
    pend_v_nxt = pend_v_r;
    pend_nxt = pend_r;
    if (emit_v) begin
      if (pend_v_r) begin
        out_nxt = pend_r;
        out_last_nxt = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt = emit_d;
      pend_v_nxt = 1'b1;
    end
    if (finish_v) begin
      out_nxt = pend_r;
      out_last_nxt = 1'b1;
      out_valid_nxt = 1'b1;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= MODE_FLUSH;
      valid_r <= '0;
      last_sweep_r <= '0;
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt;
      valid_r <= valid_nxt;
      last_sweep_r <= last_sweep_nxt;
      pend_v_r <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    now_r <= now_nxt;
    key_r <= key_nxt;
    pkt_ok_r <= pkt_ok_nxt;
    rst_r <= rst_nxt;
    fin_r <= fin_nxt;
    slot_found_r <= slot_found_nxt;
    rfound_r <= rfound_nxt;
    free_found_r <= free_found_nxt;
    slot_r <= slot_nxt;
    rslot_r <= rslot_nxt;
    free_r <= free_nxt;
    slot_phase_r <= slot_phase_nxt;
    rev_upd_r <= rev_upd_nxt;
    pend_r <= pend_nxt;
    out_r <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_kind    = out_r.kind;
  assign out_ch.flow_src_addr = out_r.key.src_addr;
  assign out_ch.flow_src_port = out_r.key.src_port;
  assign out_ch.flow_dst_addr = out_r.key.dst_addr;
  assign out_ch.flow_dst_port = out_r.key.dst_port;
  assign out_ch.flow_phase    = out_r.phase;
  assign out_ch.table_full    = out_r.full;
  assign out_ch.last          = out_last_r;
endmodule

### design/tfst_ram.sv
// ----------------------------------------------------------------------------
// tfst_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### tb/tb_if_bundle.sv
// ----------------------------------------------------------------------------
// tb_if_bundle
// Testbench-side notes: the block's own channel interfaces are reused as-is.
// ----------------------------------------------------------------------------
package tb_flow_types;
  import tfst_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] sa;
    logic [15:0] sp;
    logic [31:0] da;
    logic [15:0] dp;
    logic [1:0]  phase;
    logic        full;
    logic        last;
  } flow_event_t;
endpackage

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives packets, flushes and register writes into the flow table, predicts
// the created/deleted/processed events with a behavioral table model and
// compares every output beat in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tfst_pkg::*;
  import tb_flow_types::*;

  localparam int NSLOT = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tfst_in_if  in_ch();
  tfst_out_if out_ch();
  tfst_cfg_if cfg_ch();

  tcp_flow_state_table #(.FLOW_ENTRIES(NSLOT)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] tmo [4];
  logic [15:0] sweep_every;
  bit          slot_used [NSLOT];
  logic [63:0] slot_addrs [NSLOT];
  logic [31:0] slot_ports [NSLOT];
  logic [1:0]  slot_phase [NSLOT];
  logic [31:0] slot_seen [NSLOT];
  logic [31:0] prev_sweep;

  flow_event_t pending_events [$];
  int          errors;
  int          burst_left;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void push_event(input logic [1:0] k, input logic [63:0] a,
                                     input logic [31:0] p, input logic [1:0] ph,
                                     input logic f);
    flow_event_t e;
    e.kind = k; e.sa = a[63:32]; e.da = a[31:0]; e.sp = p[31:16]; e.dp = p[15:0];
    e.phase = ph; e.full = f; e.last = 1'b0;
    pending_events.push_back(e);
  endfunction

  function automatic int lookup_flow(input logic [63:0] a, input logic [31:0] p);
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i] && slot_addrs[i] == a && slot_ports[i] == p) return i;
    return -1;
  endfunction

  function automatic void predict_table(input logic cmd, input logic [31:0] now,
      input logic hip, input logic htcp, input logic [31:0] sa, input logic [15:0] sp,
      input logic [31:0] da, input logic [15:0] dp, input logic rb, input logic fb);
    int before_n, slot, rslot;
    logic [63:0] a, ra;
    logic [31:0] p, rp;
    logic full_f;
    logic [1:0] ph, st;
    before_n = pending_events.size();
    if (cmd) begin
      for (int i = 0; i < NSLOT; i++)
        if (slot_used[i]) begin
          push_event(EV_DELETED, slot_addrs[i], slot_ports[i], slot_phase[i], 1'b0);
          slot_used[i] = 0;
        end
    end else begin
      if (sweep_every != 0 &&
          $signed({2'b0, now}) - $signed({2'b0, prev_sweep})
            >= $signed({18'd0, sweep_every})) begin
        for (int i = 0; i < NSLOT; i++)
          if (slot_used[i] && $signed({2'b0, now}) - $signed({2'b0, slot_seen[i]})
                              >= $signed({18'd0, tmo[slot_phase[i]]})) begin
            push_event(EV_DELETED, slot_addrs[i], slot_ports[i], slot_phase[i], 1'b0);
            slot_used[i] = 0;
          end
        prev_sweep = now;
      end
      if (hip && htcp) begin
        a = {sa, da}; p = {sp, dp}; ra = {da, sa}; rp = {dp, sp};
        slot = lookup_flow(a, p);
        rslot = lookup_flow(ra, rp);
        full_f = 1'b0; ph = PH_HALF;
        if (slot < 0) begin
          for (int i = 0; i < NSLOT; i++)
            if (!slot_used[i]) begin slot = i; break; end
          if (slot < 0) full_f = 1'b1;
          else begin
            slot_used[slot] = 1; slot_addrs[slot] = a; slot_ports[slot] = p;
            slot_phase[slot] = PH_HALF;
            push_event(EV_CREATED, a, p, PH_HALF, 1'b0);
            if (rslot >= 0) begin
              slot_phase[slot] = PH_FULL; slot_phase[rslot] = PH_FULL;
            end
          end
        end
        if (slot >= 0) slot_seen[slot] = now;
        if (rb || fb) begin
          st = rb ? PH_RST : PH_FIN;
          if (slot >= 0) slot_phase[slot] = st;
          if (rslot >= 0) slot_phase[rslot] = st;
        end
        if (slot >= 0) ph = slot_phase[slot];
        push_event(EV_PROCESSED, a, p, ph, full_f);
      end
    end
    if (pending_events.size() > before_n)
      pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  // receiver: stall pattern of its own, compare each beat
  always @(posedge clk) begin
    flow_event_t w;
    if (!rst_n) out_ch.ready <= 1'b0;
    else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_events.size() == 0) begin
          report("unexpected beat kind", 64'(out_ch.event_kind), 64'd0);
        end else begin
          w = pending_events.pop_front();
          if (out_ch.event_kind !== w.kind)
            report("event_kind", 64'(out_ch.event_kind), 64'(w.kind));
          if (out_ch.flow_src_addr !== w.sa)
            report("src_addr", 64'(out_ch.flow_src_addr), 64'(w.sa));
          if (out_ch.flow_src_port !== w.sp)
            report("src_port", 64'(out_ch.flow_src_port), 64'(w.sp));
          if (out_ch.flow_dst_addr !== w.da)
            report("dst_addr", 64'(out_ch.flow_dst_addr), 64'(w.da));
          if (out_ch.flow_dst_port !== w.dp)
            report("dst_port", 64'(out_ch.flow_dst_port), 64'(w.dp));
          if (out_ch.flow_phase !== w.phase)
            report("phase", 64'(out_ch.flow_phase), 64'(w.phase));
          if (out_ch.table_full !== w.full)
            report("table_full", 64'(out_ch.table_full), 64'(w.full));
          if (out_ch.last !== w.last) report("last", 64'(out_ch.last), 64'(w.last));
        end
      end
      case ($urandom_range(0, 3))
        0: out_ch.ready <= 1'b0;
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  initial begin
    in_ch.valid = 0; in_ch.command = 0; in_ch.stamp_seconds = 0; in_ch.has_ip = 0;
    in_ch.has_tcp = 0; in_ch.source_addr = 0; in_ch.source_port = 0;
    in_ch.dest_addr = 0; in_ch.dest_port = 0; in_ch.rst_bit = 0; in_ch.fin_bit = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_HALF_TMO; cfg_ch.data = 0;
    out_ch.ready = 0;
  end

  task automatic send_beat(input logic cmd, input logic [31:0] now, input logic hip,
      input logic htcp, input logic [31:0] sa, input logic [15:0] sp,
      input logic [31:0] da, input logic [15:0] dp, input logic rb, input logic fb);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid <= 1'b1; in_ch.command <= cmd; in_ch.stamp_seconds <= now;
    in_ch.has_ip <= hip; in_ch.has_tcp <= htcp; in_ch.source_addr <= sa;
    in_ch.source_port <= sp; in_ch.dest_addr <= da; in_ch.dest_port <= dp;
    in_ch.rst_bit <= rb; in_ch.fin_bit <= fb;
    do @(posedge clk); while (!in_ch.ready);
    predict_table(cmd, now, hip, htcp, sa, sp, da, dp, rb, fb);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pkt(input logic [31:0] now, input logic [31:0] sa, input logic [15:0] sp,
      input logic [31:0] da, input logic [15:0] dp, input logic rb, input logic fb);
    send_beat(1'b0, now, 1'b1, 1'b1, sa, sp, da, dp, rb, fb);
  endtask

  task automatic wait_drain();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4 * NSLOT + 20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx <= REG_FIN_TMO) tmo[idx[1:0]] = val;
    else if (idx == REG_SWEEP_INT) sweep_every = val;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] h, input logic [15:0] f, input logic [15:0] r,
                          input logic [15:0] fi, input logic [15:0] sw);
    wait_drain();
    write_reg(REG_HALF_TMO, h); write_reg(REG_FULL_TMO, f); write_reg(REG_RST_TMO, r);
    write_reg(REG_FIN_TMO, fi); write_reg(REG_SWEEP_INT, sw);
  endtask

  task automatic test_directed();
    send_pkt(32'd5, 32'h0A000001, 16'd1000, 32'h0A000002, 16'd80, 0, 0);
    send_pkt(32'd5, 32'h0A000002, 16'd80, 32'h0A000001, 16'd1000, 0, 0);   // reverse -> full
    send_pkt(32'd6, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 0, 0); // self-reverse
    send_pkt(32'd6, 32'h0, 16'h0, 32'h0, 16'h0, 0, 1);
    send_pkt(32'd7, 32'h0A000001, 16'd1000, 32'h0A000002, 16'd80, 1, 1);   // rst wins
    send_beat(1'b0, 32'd8, 1'b0, 1'b1, 32'h1, 16'h1, 32'h2, 16'h2, 0, 0);  // no IP
    send_beat(1'b0, 32'd8, 1'b1, 1'b0, 32'h1, 16'h1, 32'h2, 16'h2, 1, 1);  // no TCP
    send_pkt(32'd3, 32'h12345678, 16'h5555, 32'h87654321, 16'hAAAA, 0, 1); // stamp backwards
    send_pkt(32'd40, 32'h1, 16'h2, 32'h3, 16'h4, 0, 0);                    // sweep ages rst/fin
    send_pkt(32'hFFFFFFFF, 32'h5, 16'h6, 32'h7, 16'h8, 0, 0);
    send_pkt(32'h80000000, 32'h9, 16'h9, 32'h9, 16'h9, 0, 0);
    send_beat(1'b1, 32'h0, 1'b1, 1'b1, 32'h0, 16'h0, 32'h0, 16'h0, 1, 0);  // flush
    send_beat(1'b1, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 0, 0);  // empty flush
  endtask

  task automatic test_table_full();
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    write_reg(3'd7, 16'h1234); // unused index is ignored
    for (int i = 0; i < NSLOT + 2; i++)
      send_pkt(32'd100, 32'hC0A80000 + i, 16'(i), 32'h0A0A0A0A, 16'd443, 0, 0);
    // reverse of a stored flow while full still flips that flow to fin
    send_pkt(32'd101, 32'h0A0A0A0A, 16'd443, 32'hC0A80003, 16'd3, 0, 1);
    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    send_pkt(32'd200, 32'h1, 16'h1, 32'h2, 16'h2, 0, 0); // stamp is behind the last sweep, so no sweep runs
    send_beat(1'b1, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 0, 0);
  endtask

  task automatic test_random(input int n, input logic [15:0] h, input logic [15:0] f,
      input logic [15:0] r, input logic [15:0] fi, input logic [15:0] sw);
    logic [31:0] hosts [6];
    logic [15:0] ports [4];
    logic [31:0] now, sa, da;
    logic [15:0] sp, dp;
    int pick;
    set_regs(h, f, r, fi, sw);
    now = $urandom_range(0, 1000) + ($urandom_range(0, 1) ? 32'hFFFFF000 : 0);
    foreach (hosts[i]) hosts[i] = $urandom;
    foreach (ports[i]) ports[i] = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      now += $urandom_range(0, 12);
      if (pick < 3) now -= $urandom_range(1, 30);
      sa = hosts[$urandom_range(0, 5)]; da = hosts[$urandom_range(0, 5)];
      sp = ports[$urandom_range(0, 3)]; dp = ports[$urandom_range(0, 3)];
      if (pick < 5) begin
        sa = $urandom; da = $urandom; sp = 16'($urandom); dp = 16'($urandom);
      end
      if (pick >= 97)
        send_beat(1'b1, $urandom, 1'($urandom), 1'($urandom), $urandom, 16'($urandom),
                  $urandom, 16'($urandom), 1'($urandom), 1'($urandom));
      else if (pick >= 92)
        send_beat(1'b0, now, 1'($urandom_range(0, 1)), 1'b0, sa, sp, da, dp,
                  1'($urandom), 1'($urandom));
      else
        send_pkt(now, sa, sp, da, dp, $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    errors = 0; burst_left = 0;
    tmo[0] = 16'd60; tmo[1] = 16'd180; tmo[2] = 16'd10; tmo[3] = 16'd20;
    sweep_every = 16'd1; prev_sweep = 0;
    foreach (slot_used[i]) slot_used[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(110, 16'd40, 16'd90, 16'd8, 16'd15, 16'd3);
    test_random(80, 16'd5, 16'd10, 16'd2, 16'd3, 16'd1);
    test_random(80, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd65535);
    test_random(60, 16'd30, 16'd60, 16'd20, 16'd20, 16'd0);
    wait_drain();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

### tcp_flow_state_table.f
design/tfst_pkg.sv
design/tfst_in_if.sv
design/tfst_out_if.sv
design/tfst_cfg_if.sv
design/tfst_ram.sv
design/tcp_flow_state_table.sv
tb/tb_if_bundle.sv
tb/testbench.sv
